/* sv/assert_macros.svh */
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// check a property on every clock edge outside reset
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`endif

/* sv/msa_pkg.sv */
// shared types for the maximum size switch allocator
// no dependencies
package msa_pkg;
   typedef enum logic [2:0] {
      ST_LOAD,
      ST_SEED,
      ST_SCAN,
      ST_FLIP,
      ST_EMIT
   } msa_state_type;

   typedef struct packed {
      logic clear_match;
      logic seed;
      logic scan;
      logic flip;
      logic finish;
      logic emit;
   } msa_cmd_type;

   typedef struct packed {
      logic scan_found;
      logic scan_dead;
      logic flip_done;
      logic emit_last;
   } msa_status_type;
endpackage

/* sv/msa_datapath.sv */
// matrix store, matching registers and augmenting path search datapath
// depends on msa_pkg
module msa_datapath import msa_pkg::*; #(
   parameter int NUM_INPUTS  = 8,
   parameter int NUM_OUTPUTS = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load_row,
   input  logic [7:0]           req_row,
   input  msa_cmd_type          cmd,
   output msa_status_type       status,
   output logic [2:0]           rsp_input_index,
   output logic                 rsp_granted,
   output logic [2:0]           rsp_output_index,
   output logic                 rsp_grant_last
);
   localparam int IW = (NUM_INPUTS > 1) ? $clog2(NUM_INPUTS) : 1;
   localparam int OW = (NUM_OUTPUTS > 1) ? $clog2(NUM_OUTPUTS) : 1;
   localparam int CW = $clog2(NUM_INPUTS + 1);

   logic [NUM_OUTPUTS-1:0] matrix_ff [NUM_INPUTS];
   logic [CW-1:0]          count_ff;
   logic [IW-1:0]          prio_ff;
   logic [NUM_INPUTS-1:0]  lok_ff;
   logic [OW-1:0]          lmatch_ff [NUM_INPUTS];
   logic [NUM_OUTPUTS-1:0] rok_ff;
   logic [IW-1:0]          rmatch_ff [NUM_OUTPUTS];
   logic [NUM_OUTPUTS-1:0] reached_ff;
   logic [IW-1:0]          from_ff [NUM_OUTPUTS];
   // bfs layers as ordered input lists
   logic [IW-1:0]          cur_list_ff [NUM_INPUTS];
   logic [IW-1:0]          nxt_list_ff [NUM_INPUTS];
   logic [CW-1:0]          cur_len_ff, nxt_len_ff;
   logic [IW-1:0]          pos_ff;
   logic [CW-1:0]          layer_ff;
   logic [OW-1:0]          fj_ff;
   logic [IW-1:0]          emit_ff;

   logic [IW-1:0] cur_i;
   logic [NUM_OUTPUTS-1:0] cand;
   logic found_free;
   logic [OW-1:0] free_j;
   logic [NUM_OUTPUTS-1:0] new_reach;
   logic [IW-1:0] seed_list [NUM_INPUTS];
   logic [CW-1:0] seed_len;
   logic [IW-1:0] app_list [NUM_INPUTS];
   logic [CW-1:0] app_len;
   logic layer_last;
   logic [IW-1:0] flip_i;

   // unmatched inputs in rotated order from the priority pointer
   always_comb begin
      logic [IW:0] r;
      seed_len = '0;
      r = '0;
      for (int k = 0; k < NUM_INPUTS; k++) seed_list[k] = '0;
      for (int k = 0; k < NUM_INPUTS; k++) begin
         r = (IW+1)'(k) + {1'b0, prio_ff};
         if (r >= (IW+1)'(NUM_INPUTS)) r = r - (IW+1)'(NUM_INPUTS);
         if (!lok_ff[r[IW-1:0]]) begin
            seed_list[seed_len[IW-1:0]] = r[IW-1:0];
            seed_len = seed_len + 1'b1;
         end
      end
   end

   always_comb begin
      cur_i = cur_list_ff[pos_ff];
      layer_last = (CW'(pos_ff) + CW'(1)) >= cur_len_ff;
      cand = matrix_ff[cur_i] & ~reached_ff;
      if (lok_ff[cur_i]) cand[lmatch_ff[cur_i]] = 1'b0;
      if (cur_len_ff == '0) cand = '0;
      found_free = 1'b0;
      free_j = '0;
      new_reach = cand;
      app_list = nxt_list_ff;
      app_len = nxt_len_ff;
      for (int j = NUM_OUTPUTS - 1; j >= 0; j--) begin
         if (cand[j] && !rok_ff[j]) begin
            found_free = 1'b1;
            free_j = OW'(j);
         end
      end
      // next layer keeps discovery order
      for (int j = 0; j < NUM_OUTPUTS; j++) begin
         if (found_free && OW'(j) > free_j) new_reach[j] = 1'b0;
         if (new_reach[j] && rok_ff[j] && app_len < CW'(NUM_INPUTS)) begin
            app_list[app_len[IW-1:0]] = rmatch_ff[j];
            app_len = app_len + 1'b1;
         end
      end
      flip_i = from_ff[fj_ff];
   end

   assign status.scan_found = cmd.scan && found_free;
   assign status.scan_dead  = cmd.scan && !found_free && layer_last &&
                              (app_len == '0 ||
                               layer_ff == CW'(NUM_INPUTS - 1));
   assign status.flip_done  = cmd.flip && !lok_ff[flip_i];
   assign status.emit_last  = cmd.emit && emit_ff == IW'(NUM_INPUTS - 1);

   assign rsp_input_index  = 3'(emit_ff);
   assign rsp_granted      = lok_ff[emit_ff];
   assign rsp_output_index = lok_ff[emit_ff] ? 3'(lmatch_ff[emit_ff]) : 3'd0;
   assign rsp_grant_last   = emit_ff == IW'(NUM_INPUTS - 1);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         prio_ff  <= '0;
         lok_ff   <= '0;
         rok_ff   <= '0;
         emit_ff  <= '0;
         for (int i = 0; i < NUM_INPUTS; i++) matrix_ff[i] <= '0;
      end else begin
         if (load_row && count_ff < CW'(NUM_INPUTS)) begin
            matrix_ff[count_ff[IW-1:0]] <= req_row[NUM_OUTPUTS-1:0];
            count_ff <= count_ff + 1'b1;
         end
         if (cmd.clear_match) begin
            lok_ff <= '0;
            rok_ff <= '0;
         end
         if (cmd.seed) begin
            reached_ff  <= '0;
            cur_list_ff <= seed_list;
            cur_len_ff  <= seed_len;
            nxt_len_ff  <= '0;
            pos_ff      <= '0;
            layer_ff    <= '0;
         end
         if (cmd.scan) begin
            reached_ff <= reached_ff | new_reach;
            for (int j = 0; j < NUM_OUTPUTS; j++)
               if (new_reach[j]) from_ff[j] <= cur_i;
            if (found_free) begin
               fj_ff <= free_j;
            end else if (layer_last) begin
               cur_list_ff <= app_list;
               cur_len_ff  <= app_len;
               nxt_len_ff  <= '0;
               pos_ff      <= '0;
               layer_ff    <= layer_ff + 1'b1;
            end else begin
               nxt_list_ff <= app_list;
               nxt_len_ff  <= app_len;
               pos_ff      <= pos_ff + 1'b1;
            end
         end
         if (cmd.flip) begin
            rmatch_ff[fj_ff] <= flip_i;
            rok_ff[fj_ff]    <= 1'b1;
            lmatch_ff[flip_i] <= fj_ff;
            lok_ff[flip_i]    <= 1'b1;
            fj_ff <= lmatch_ff[flip_i];
         end
         if (cmd.finish) begin
            prio_ff  <= (prio_ff == IW'(NUM_INPUTS - 1)) ? '0 : prio_ff + 1'b1;
            count_ff <= '0;
            emit_ff  <= '0;
         end
         if (cmd.emit) begin
            emit_ff <= (emit_ff == IW'(NUM_INPUTS - 1)) ? '0 : emit_ff + 1'b1;
            if (emit_ff == IW'(NUM_INPUTS - 1))
               for (int i = 0; i < NUM_INPUTS; i++) matrix_ff[i] <= '0;
         end
      end
   end
endmodule

/* sv/msa_control.sv */
// allocation sequencer state machine
// depends on msa_pkg
module msa_control import msa_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   input  logic           req_row_last,
   input  logic           rsp_ready,
   input  msa_status_type status,
   output logic           req_ready,
   output logic           rsp_valid,
   output logic           load_row,
   output msa_cmd_type    cmd
);
   msa_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_LOAD;
      else       state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_LOAD: if (req_valid && req_row_last) state_in = ST_SEED;
         ST_SEED: state_in = ST_SCAN;
         ST_SCAN: begin
            if (status.scan_found)     state_in = ST_FLIP;
            else if (status.scan_dead) state_in = ST_EMIT;
         end
         ST_FLIP: if (status.flip_done) state_in = ST_SEED;
         ST_EMIT: if (rsp_ready && status.emit_last) state_in = ST_LOAD;
         default: state_in = ST_LOAD;
      endcase
   end

   always_comb begin
      cmd = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_LOAD: begin
            req_ready = 1'b1;
            cmd.clear_match = 1'b1;
         end
         ST_SEED: cmd.seed = 1'b1;
         ST_SCAN: begin
            cmd.scan = 1'b1;
            cmd.finish = status.scan_dead;
         end
         ST_FLIP: cmd.flip = 1'b1;
         ST_EMIT: begin
            rsp_valid = 1'b1;
            cmd.emit = rsp_ready;
         end
         default: ;
      endcase
      load_row = req_valid && req_ready;
   end
endmodule

/* sv/max_size_switch_allocator.sv */
// rows are stored in order as they are accepted; after the last row each augmenting path search takes
// a seed step, a scan step per frontier input and a flip step per flipped edge
// at most NUM_INPUTS+1 searches run, then NUM_INPUTS result words are sent
// throughput: one matrix at a time; rows are refused from the last row until the last result
// synchronous reset clears matching, row count, priority and the stored rows
module max_size_switch_allocator import msa_pkg::*; #(
   parameter int NUM_INPUTS  = 8,
   parameter int NUM_OUTPUTS = 8
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_row,
   input  logic       req_row_last,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [2:0] rsp_input_index,
   output logic       rsp_granted,
   output logic [2:0] rsp_output_index,
   output logic       rsp_grant_last
);
   msa_cmd_type    cmd;
   msa_status_type status;
   logic           load_row;

   msa_control u_ctrl (
      .clock, .reset, .req_valid, .req_row_last, .rsp_ready, .status,
      .req_ready, .rsp_valid, .load_row, .cmd
   );

   msa_datapath #(.NUM_INPUTS(NUM_INPUTS), .NUM_OUTPUTS(NUM_OUTPUTS)) u_dp (
      .clock, .reset, .load_row, .req_row, .cmd, .status,
      .rsp_input_index, .rsp_granted, .rsp_output_index, .rsp_grant_last
   );
endmodule

/* sv/msa_checker.sv */
// port level checks for the allocator
// depends on assert_macros.svh
`include "assert_macros.svh"
module msa_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [2:0] rsp_input_index,
   input logic       rsp_grant_last
);
   `ASSERT_CLK(a_no_overlap, clock, reset, !(req_ready && rsp_valid), "ready during results")
   `ASSERT_CLK(a_first_zero, clock, reset, $rose(rsp_valid) |-> rsp_input_index == 3'd0, "first word not input 0")
   `ASSERT_CLK(a_step, clock, reset, (rsp_valid && rsp_ready && !rsp_grant_last) |=> rsp_valid && rsp_input_index == $past(rsp_input_index) + 3'd1, "index skip")
   `ASSERT_CLK(a_end, clock, reset, (rsp_valid && rsp_ready && rsp_grant_last) |=> !rsp_valid, "results after last")
endmodule

bind max_size_switch_allocator msa_checker u_chk (
   .clock, .reset, .req_ready, .rsp_valid, .rsp_ready,
   .rsp_input_index, .rsp_grant_last
);
